### rtl/lrut_pkg.sv
`timescale 1ns / 1ps

package lrut_pkg;

    localparam int ADDR_W        = 64;
    localparam int LSZ_W         = 4;
    localparam int CAP_W         = 7;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 7;
    localparam int DEF_MAX_LINES = 64;

    localparam logic [LSZ_W-1:0] LSZ_RESET = LSZ_W'(6);
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LINE_SIZE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = CFG_IDX_W'(1);

    // Command codes.
    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_DUMP   = 1'b1;

    // Per-cell update control: take the neighbor's tag, or take the insert bus.
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

### rtl/lrut_cell.sv
`timescale 1ns / 1ps

module lrut_cell (
    input  logic                        i_clk,
    input  lrut_pkg::t_cell_ctl         i_ctl,
    input  logic                        i_valid,
    input  logic [lrut_pkg::ADDR_W-1:0] i_line,
    input  logic [lrut_pkg::ADDR_W-1:0] i_next_tag,
    input  logic [lrut_pkg::ADDR_W-1:0] i_ins_tag,
    output logic [lrut_pkg::ADDR_W-1:0] o_tag,
    output logic                        o_match
);

    logic [lrut_pkg::ADDR_W-1:0] r_tag;
    logic [lrut_pkg::ADDR_W-1:0] n_tag;

    always_comb begin
        if (i_ctl.load) begin
            n_tag = i_ins_tag;
        end else if (i_ctl.shift) begin
            n_tag = i_next_tag;
        end else begin
            n_tag = r_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag <= n_tag;
    end

    assign o_tag   = r_tag;
    assign o_match = i_valid && (r_tag == i_line);

endmodule

### rtl/lru_line_tracker.sv
`timescale 1ns / 1ps
// Access: accepted on start, result strobed from S_ACC; no new request until back in idle.
// The tag compare runs in the accept cycle, the recency shift through the cell row in the next.
// Dump: one entry per cycle oldest first as the row rotates in S_DUMP, starting the cycle after
// the request, each entry registered onto the outputs; no request is taken until the dump ends.
// Synchronous active-low reset empties the store and restores the register defaults.
// The receiver cannot stall: each result is presented for exactly one cycle.
module lru_line_tracker #(
    parameter int MAX_LINES = lrut_pkg::DEF_MAX_LINES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_command,
    input  logic [lrut_pkg::ADDR_W-1:0]     i_address,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lrut_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lrut_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_result_valid,
    output logic                            o_hit,
    output logic                            o_evicted,
    output logic                            o_entry_valid,
    output logic [lrut_pkg::ADDR_W-1:0]     o_line_address,
    output logic                            o_last
);

    localparam int CNT_W = $clog2(MAX_LINES + 1);
    localparam int IDX_W = $clog2(MAX_LINES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACC,
        S_DUMP
    } t_state;

    t_state                          r_state;
    logic [lrut_pkg::LSZ_W-1:0]      r_lsz;
    logic [lrut_pkg::CAP_W-1:0]      r_cap;
    logic [CNT_W-1:0]                r_held;
    logic [IDX_W-1:0]                r_cnt;
    logic [lrut_pkg::ADDR_W-1:0]     r_line;
    logic                            r_hit_any;
    logic [IDX_W-1:0]                r_hit_pos;

    logic [lrut_pkg::ADDR_W-1:0]     line_in;
    logic [lrut_pkg::CAP_W-1:0]      cap_sat;
    logic [CNT_W-1:0]                cap_eff;
    logic [CNT_W-1:0]                held_m1;
    logic [MAX_LINES-1:0]            cell_valid;
    logic [MAX_LINES-1:0]            cell_match;
    logic                            hit_any;
    logic [IDX_W-1:0]                hit_pos;
    logic                            upd_en;
    logic [CNT_W-1:0]                upd_lo;
    logic [CNT_W-1:0]                upd_hi;
    logic [lrut_pkg::ADDR_W-1:0]     ins_tag;
    logic                            room;
    logic                            in_accept;
    logic                            cfg_accept;
    lrut_pkg::t_cell_ctl             cell_ctl [MAX_LINES];
    logic [lrut_pkg::ADDR_W-1:0]     cell_tag [MAX_LINES];

    // A register write takes the cycle, so no request is taken beside it.
    assign busy        = (r_state != S_IDLE) || i_cfg_valid || !i_rst_n;
    assign o_cfg_ready = (r_state == S_IDLE) && i_rst_n;
    assign in_accept   = start && !busy;
    assign cfg_accept  = i_cfg_valid && o_cfg_ready;

    always_comb begin
        line_in = i_address & ((~lrut_pkg::ADDR_W'(0)) << r_lsz);
        if (r_cap == '0) begin
            cap_sat = lrut_pkg::CAP_W'(1);
        end else if (r_cap > lrut_pkg::CAP_W'(MAX_LINES)) begin
            cap_sat = lrut_pkg::CAP_W'(MAX_LINES);
        end else begin
            cap_sat = r_cap;
        end
        cap_eff = CNT_W'(cap_sat);
        held_m1 = r_held - CNT_W'(1);
        room    = r_held < cap_eff;
        for (int i = 0; i < MAX_LINES; i++) begin
            cell_valid[i] = CNT_W'(i) < r_held;
        end
        // Live tags are distinct, so at most one cell matches.
        hit_any = |cell_match;
        hit_pos = '0;
        for (int i = 0; i < MAX_LINES; i++) begin
            if (cell_match[i]) begin
                hit_pos = hit_pos | IDX_W'(i);
            end
        end
    end

    // The cells between lo and hi take their younger neighbor's tag; cell hi takes
    // the insert bus. A dump rotates the oldest tag around to the newest position.
    always_comb begin
        upd_en  = 1'b0;
        upd_lo  = '0;
        upd_hi  = held_m1;
        ins_tag = r_line;
        case (r_state)
            S_ACC: begin
                upd_en = 1'b1;
                if (r_hit_any) begin
                    upd_lo = CNT_W'(r_hit_pos);
                end else if (room) begin
                    upd_lo = r_held;
                    upd_hi = r_held;
                end
            end
            S_DUMP: begin
                upd_en  = 1'b1;
                ins_tag = cell_tag[0];
            end
            default: begin
                upd_en = 1'b0;
            end
        endcase
        for (int i = 0; i < MAX_LINES; i++) begin
            cell_ctl[i].shift = upd_en && (CNT_W'(i) >= upd_lo) && (CNT_W'(i) < upd_hi);
            cell_ctl[i].load  = upd_en && (CNT_W'(i) == upd_hi);
        end
    end

    for (genvar g = 0; g < MAX_LINES; g++) begin : g_cell
        logic [lrut_pkg::ADDR_W-1:0] next_tag;
        if (g == MAX_LINES - 1) begin : g_end
            assign next_tag = '0;
        end else begin : g_mid
            assign next_tag = cell_tag[g+1];
        end
        lrut_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (cell_ctl[g]),
            .i_valid    (cell_valid[g]),
            .i_line     (line_in),
            .i_next_tag (next_tag),
            .i_ins_tag  (ins_tag),
            .o_tag      (cell_tag[g]),
            .o_match    (cell_match[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_lsz          <= lrut_pkg::LSZ_RESET;
            r_cap          <= lrut_pkg::CAP_RESET;
            r_held         <= '0;
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= 1'b0;
            if (cfg_accept) begin
                unique case (i_cfg_index)
                    lrut_pkg::REG_LINE_SIZE: begin
                        r_lsz  <= i_cfg_data[lrut_pkg::LSZ_W-1:0];
                        r_held <= '0;
                    end
                    lrut_pkg::REG_CAPACITY: begin
                        r_cap  <= lrut_pkg::CAP_W'(i_cfg_data);
                        r_held <= '0;
                    end
                    default: begin
                        r_held <= r_held;
                    end
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_line    <= line_in;
                        r_hit_any <= hit_any;
                        r_hit_pos <= hit_pos;
                        r_cnt     <= '0;
                        if (i_command == lrut_pkg::CMD_DUMP) begin
                            if (r_held == '0) begin
                                o_result_valid <= 1'b1;
                                o_hit          <= 1'b0;
                                o_evicted      <= 1'b0;
                                o_entry_valid  <= 1'b0;
                                o_line_address <= '0;
                                o_last         <= 1'b1;
                            end else begin
                                r_state <= S_DUMP;
                            end
                        end else begin
                            r_state <= S_ACC;
                        end
                    end
                end
                S_ACC: begin
                    o_result_valid <= 1'b1;
                    o_hit          <= r_hit_any;
                    o_evicted      <= !r_hit_any && !room;
                    o_entry_valid  <= !r_hit_any && !room;
                    o_line_address <= (!r_hit_any && !room) ? cell_tag[0] : '0;
                    o_last         <= 1'b1;
                    if (!r_hit_any && room) begin
                        r_held <= r_held + CNT_W'(1);
                    end
                    r_state <= S_IDLE;
                end
                S_DUMP: begin
                    o_result_valid <= 1'b1;
                    o_hit          <= 1'b0;
                    o_evicted      <= 1'b0;
                    o_entry_valid  <= 1'b1;
                    o_line_address <= cell_tag[0];
                    o_last         <= (r_cnt == held_m1[IDX_W-1:0]);
                    r_cnt          <= r_cnt + IDX_W'(1);
                    if (r_cnt == held_m1[IDX_W-1:0]) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_held_within_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= cap_eff)
        else $error("held line count exceeds the effective capacity");

    a_access_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ACC |=> o_result_valid && o_last && r_state == S_IDLE)
        else $error("access did not finish with one final result");

    a_hit_excludes_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !(o_hit && o_evicted))
        else $error("result reports both a hit and an eviction");

    a_dump_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_state) == S_DUMP |-> o_result_valid && o_entry_valid && !o_evicted)
        else $error("dump produced a malformed result");

endmodule
